FILE: src/rfc_pkg.sv
// ----------------------------------------------------------------------------
// RS485 frame checker package
// Shared types, codes and arithmetic helpers for the frame checker.
// ----------------------------------------------------------------------------
package rfc_pkg;

	localparam int FrameLenDefault = 10;
	localparam int OrderPosDefault = 2;
	localparam int PosMaxW         = 6;
	localparam int QueueDepth      = 2;

	localparam int SumW      = 16;
	localparam int DivW      = 18;
	localparam int RedSteps  = DivW / 2;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 16;
	localparam int ParamCnt  = 5;

	localparam logic [7:0]      StartCode  = 8'hAA;
	localparam logic [SumW-1:0] Recip255   = 16'h8081;
	localparam logic [7:0]      Const255   = 8'hFF;
	localparam logic [7:0]      LimitHandle = 8'h10;
	localparam logic [7:0]      LimitMaster = 8'h20;
	localparam logic [7:0]      LimitSensor = 8'h30;

	localparam logic [CfgIdxW-1:0] CfgModulus   = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgLocal     = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgBroadcast = 2'd2;

	localparam logic [SumW-1:0] ModulusReset   = 16'd65025;
	localparam logic [7:0]      LocalReset     = 8'd16;
	localparam logic [7:0]      BroadcastReset = 8'd0;

	localparam logic [1:0] StatusOk       = 2'd0;
	localparam logic [1:0] StatusBadStart = 2'd1;
	localparam logic [1:0] StatusBadSum   = 2'd2;
	localparam logic [1:0] StatusNotHere  = 2'd3;

	localparam logic [1:0] ClassHandle = 2'd0;
	localparam logic [1:0] ClassMaster = 2'd1;
	localparam logic [1:0] ClassSensor = 2'd2;
	localparam logic [1:0] ClassOther  = 2'd3;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_begin;
	} rfc_input_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] source_address;
		logic [1:0] source_class;
		logic [7:0] command;
		logic [7:0] param_zero;
		logic [7:0] param_one;
		logic [7:0] param_two;
		logic [7:0] param_three;
	} rfc_result_t;

	typedef struct packed {
		logic [7:0]         data;
		logic [PosMaxW-1:0] pos;
		logic               add_sum;
		logic               last;
	} rfc_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rfc_qstat_t;

	typedef struct packed {
		logic [SumW-1:0] modulus;
		logic [7:0]      own_address;
		logic [7:0]      broadcast_address;
	} rfc_cfg_t;

	// One restoring division step that keeps only the remainder.
	function automatic logic [SumW-1:0] rem_step(logic [SumW-1:0] rem, logic din,
		logic [SumW-1:0] m);
		logic [SumW:0] r;
		r = {rem, din};
		if (r >= {1'b0, m}) begin
			r = r - {1'b0, m};
		end
		return r[SumW-1:0];
	endfunction

	// A checksum byte must never look like the start code.
	function automatic logic [7:0] avoid_start(logic [7:0] v);
		logic [7:0] r;
		r = v;
		if (v == StartCode) begin
			r = v - 8'd1;
		end
		return r;
	endfunction

endpackage

FILE: src/rfc_front.sv
// ----------------------------------------------------------------------------
// RS485 frame checker front end
// Accepts received bytes, tracks the frame position and tags each byte.
// ----------------------------------------------------------------------------
module rfc_front #(
	parameter int FRAME_LEN = rfc_pkg::FrameLenDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  rfc_pkg::rfc_input_t item,
	output logic               q_push,
	output rfc_pkg::rfc_item_t  q_item,
	input  rfc_pkg::rfc_qstat_t q_stat
);
	import rfc_pkg::*;

	localparam int PosW = $clog2(FRAME_LEN);
	localparam logic [PosW-1:0] PosLast = PosW'(FRAME_LEN - 1);
	localparam logic [PosW-1:0] PosSumLast = PosW'(FRAME_LEN - 2);
	localparam logic [PosW-1:0] PosSumFirst = PosW'(2);

	logic [PosW-1:0] pos_q;
	logic [PosW-1:0] pos_cur;
	logic            accept;

	assign full    = q_stat.full;
	assign accept  = push && !q_stat.full;
	assign q_push  = accept;
	assign pos_cur = item.frame_begin ? '0 : pos_q;

	always_comb begin
		q_item         = '0;
		q_item.data    = item.rx_byte;
		q_item.pos     = PosMaxW'(pos_cur);
		q_item.add_sum = (pos_cur >= PosSumFirst) && (pos_cur <= PosSumLast);
		q_item.last    = (pos_cur == PosLast);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (pos_cur == PosLast) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_cur + PosW'(1);
			end
		end
	end

endmodule

FILE: src/rfc_queue.sv
// ----------------------------------------------------------------------------
// RS485 frame checker item queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module rfc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rfc_pkg::rfc_item_t  wr_item,
	input  logic               pop,
	output rfc_pkg::rfc_item_t  rd_item,
	output rfc_pkg::rfc_qstat_t stat
);
	import rfc_pkg::*;

	localparam int PtrW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	rfc_item_t       mem [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign stat.full  = (count_q == CntW'(QueueDepth));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_item    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

FILE: src/rfc_back.sv
// ----------------------------------------------------------------------------
// RS485 frame checker back end
// Stores frame bytes, keeps the weighted checksum and checks finished frames.
// ----------------------------------------------------------------------------
module rfc_back #(
	parameter int FRAME_LEN = rfc_pkg::FrameLenDefault,
	parameter int ORDER_POS = rfc_pkg::OrderPosDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rfc_pkg::rfc_item_t   q_item,
	input  rfc_pkg::rfc_qstat_t  q_stat,
	output logic                q_pop,
	input  rfc_pkg::rfc_cfg_t    cfg,
	output logic                empty,
	input  logic                pop,
	output rfc_pkg::rfc_result_t result
);
	import rfc_pkg::*;

	localparam int PosW  = $clog2(FRAME_LEN);
	localparam int ProdW = 8 + PosW;
	localparam int CntW  = $clog2(RedSteps);
	localparam logic [PosW-1:0] IdxLast = PosW'(FRAME_LEN - 1);
	localparam logic [PosW-1:0] IdxDst  = PosW'(FRAME_LEN - 2);
	localparam logic [PosW-1:0] IdxSrc  = PosW'(FRAME_LEN - 3);
	localparam logic [PosW-1:0] IdxHi   = PosW'(1);
	localparam logic [PosW-1:0] IdxLo   = PosW'(0);

	localparam logic [2:0] StIdle   = 3'd0;
	localparam logic [2:0] StReduce = 3'd1;
	localparam logic [2:0] StSplit  = 3'd2;
	localparam logic [2:0] StDivide = 3'd3;
	localparam logic [2:0] StReport = 3'd4;

	logic [7:0]          store [FRAME_LEN];
	logic [2:0]          state_q;
	logic [SumW-1:0]     sum_q;
	logic [DivW-1:0]     div_q;
	logic [SumW-1:0]     rem_q;
	logic [CntW-1:0]     cnt_q;
	logic [2*SumW-1:0]   prod_q;
	logic [7:0]          hi_q;
	logic [7:0]          lo_q;
	logic                out_valid_q;
	rfc_result_t         out_q;

	logic [ProdW-1:0]    mul;
	logic [DivW-1:0]     sum_next;
	logic [SumW-1:0]     rem_a;
	logic [SumW-1:0]     rem_b;
	logic [8:0]          q_est;
	logic [8:0]          q_fix;
	logic [SumW:0]       q_mul;
	logic [SumW:0]       r_est;
	logic [SumW:0]       r_fix;
	logic [7:0]          par [ParamCnt];
	logic [7:0]          src;
	logic [7:0]          dst;
	rfc_result_t         res;
	logic                take;
	logic                emit;
	logic                pop_ok;

	assign q_pop  = (state_q == StIdle) && !q_stat.empty;
	assign take   = q_pop;
	assign pop_ok = pop && out_valid_q;
	assign emit   = (state_q == StReport) && (!out_valid_q || pop);
	assign empty  = !out_valid_q;
	assign result = out_q;
	assign src    = store[IdxSrc];
	assign dst    = store[IdxDst];

	for (genvar k = 0; k < ParamCnt; k++) begin : g_par
		if (ORDER_POS + k < FRAME_LEN) begin : g_in
			assign par[k] = store[PosW'(ORDER_POS + k)];
		end else begin : g_out
			assign par[k] = 8'h00;
		end
	end

	always_comb begin
		mul      = ProdW'(q_item.data) * ProdW'(q_item.pos[PosW-1:0]);
		sum_next = DivW'(sum_q) + DivW'(mul);
		rem_a    = rem_step(rem_q, div_q[DivW-1], cfg.modulus);
		rem_b    = rem_step(rem_a, div_q[DivW-2], cfg.modulus);

		q_est = prod_q[31:23];
		q_mul = {q_est, 8'h00} - (SumW+1)'(q_est);
		r_est = {1'b0, sum_q} - q_mul;
		q_fix = q_est;
		r_fix = r_est;
		if (r_est >= (SumW+1)'(Const255)) begin
			q_fix = q_est + 9'd1;
			r_fix = r_est - (SumW+1)'(Const255);
		end
	end

	always_comb begin
		res                = '0;
		res.source_address = src;
		if (store[IdxLast] != StartCode) begin
			res.status = StatusBadStart;
		end else if (store[IdxHi] != hi_q || store[IdxLo] != lo_q) begin
			res.status = StatusBadSum;
		end else if (dst != cfg.own_address && dst != cfg.broadcast_address) begin
			res.status = StatusNotHere;
		end else begin
			res.status = StatusOk;
		end
		if (src < LimitHandle) begin
			res.source_class = ClassHandle;
		end else if (src < LimitMaster) begin
			res.source_class = ClassMaster;
		end else if (src < LimitSensor) begin
			res.source_class = ClassSensor;
		end else begin
			res.source_class = ClassOther;
		end
		if (res.status == StatusOk) begin
			res.command     = par[0];
			res.param_zero  = par[1];
			res.param_one   = par[2];
			res.param_two   = par[3];
			res.param_three = par[4];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			store[q_item.pos[PosW-1:0]] <= q_item.data;
			div_q <= sum_next;
			rem_q <= '0;
		end else if (state_q == StReduce) begin
			div_q <= {div_q[DivW-3:0], 2'b00};
			rem_q <= rem_b;
		end
		if (state_q == StSplit) begin
			prod_q <= sum_q * Recip255;
		end
		if (state_q == StDivide) begin
			hi_q <= avoid_start(q_fix[7:0]);
			lo_q <= avoid_start(r_fix[7:0]);
		end
		if (emit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				StIdle: begin
					if (take) begin
						cnt_q <= '0;
						if (q_item.pos == '0) begin
							sum_q <= '0;
						end
						if (q_item.add_sum) begin
							if (cfg.modulus == '0) begin
								sum_q <= sum_next[SumW-1:0];
							end else begin
								state_q <= StReduce;
							end
						end else if (q_item.last) begin
							state_q <= StSplit;
						end
					end
				end
				StReduce: begin
					cnt_q <= cnt_q + CntW'(1);
					if (cnt_q == CntW'(RedSteps - 1)) begin
						sum_q   <= rem_b;
						state_q <= StIdle;
					end
				end
				StSplit: begin
					state_q <= StDivide;
				end
				StDivide: begin
					state_q <= StReport;
				end
				StReport: begin
					if (emit) begin
						sum_q   <= '0;
						state_q <= StIdle;
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop_ok) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/rs485_frame_checker.sv
// ----------------------------------------------------------------------------
// RS485 frame checker
// Checks received frames for start code, weighted checksum and destination.
// A byte that adds to the checksum holds the back end while it is taken and
// then put through the two-bit-per-cycle modular reduction (no reduction
// when the modulus is zero). The last byte of a frame leads the back end
// through the split, divide and report states, and its result is registered
// once the result register is free or being popped.
// A two-entry queue lets the front take bytes while the back end works.
// Reset clears position, checksum, queue and result valid flag at once.
// ----------------------------------------------------------------------------
module rs485_frame_checker #(
	parameter int FRAME_LEN = rfc_pkg::FrameLenDefault,
	parameter int ORDER_POS = rfc_pkg::OrderPosDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  rfc_pkg::rfc_input_t             item,
	output logic                           empty,
	input  logic                           pop,
	output rfc_pkg::rfc_result_t            result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rfc_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [rfc_pkg::CfgDataW-1:0]   cfg_data
);
	import rfc_pkg::*;

	rfc_cfg_t   cfg_q;
	rfc_item_t  f_item;
	rfc_item_t  b_item;
	rfc_qstat_t q_stat;
	logic       f_push;
	logic       b_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.modulus           <= ModulusReset;
			cfg_q.own_address       <= LocalReset;
			cfg_q.broadcast_address <= BroadcastReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CfgModulus:   cfg_q.modulus           <= cfg_data;
				CfgLocal:     cfg_q.own_address       <= cfg_data[7:0];
				CfgBroadcast: cfg_q.broadcast_address <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	rfc_front #(
		.FRAME_LEN(FRAME_LEN)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.q_push(f_push),
		.q_item(f_item),
		.q_stat(q_stat)
	);

	rfc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wr_item(f_item),
		.pop    (b_pop),
		.rd_item(b_item),
		.stat   (q_stat)
	);

	rfc_back #(
		.FRAME_LEN(FRAME_LEN),
		.ORDER_POS(ORDER_POS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.q_item(b_item),
		.q_stat(q_stat),
		.q_pop (b_pop),
		.cfg   (cfg_q),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("item queue reports full and empty together");

	a_reject_clears_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != StatusOk) |-> (result.command == 8'h00 &&
		result.param_zero == 8'h00 && result.param_one == 8'h00 &&
		result.param_two == 8'h00 && result.param_three == 8'h00))
		else $error("rejected frame carries command or parameters");

	a_class_match: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((result.source_class == ClassHandle) ==
		(result.source_address < LimitHandle)))
		else $error("source class disagrees with source address");

	a_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !b_pop) |=> full)
		else $error("queue left full without a pop");

endmodule

FILE: dv/rs485_frame_checker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RS485 frame checker testbench
// Streams directed and random frames through the checker under several
// register settings. The random frames are well formed, corrupted or broken
// off. A predictor tracks the byte position, the running weighted checksum
// and the frame contents, and every report is compared with its output.
// ----------------------------------------------------------------------------
module rs485_frame_checker_tb;
	import rfc_pkg::*;

	localparam int FrameLen       = FrameLenDefault;
	localparam int OrderPos       = OrderPosDefault;
	localparam int CycleLimit     = 200000;
	localparam int DrainCycles    = 40;
	localparam int PhaseCount     = 6;
	localparam int EventsPerPhase = 6;
	localparam int ReportLimit    = 10;
	localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

	typedef enum int {
		FrameToLocal,
		FrameToBroadcast,
		FrameBadStart,
		FrameBadSum,
		FrameNotHere
	} frame_kind_e;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                push      = 1'b0;
	logic                full;
	rfc_input_t          item      = '0;
	logic                empty;
	logic                pop       = 1'b0;
	rfc_result_t         result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data  = '0;

	logic [15:0] cfg_modulus  = ModulusReset;
	logic [7:0]  cfg_own      = LocalReset;
	logic [7:0]  cfg_bcast    = BroadcastReset;
	logic [5:0]  frame_pos    = '0;
	logic [15:0] weighted_sum = '0;
	logic [7:0]  frame_bytes [FrameLen];

	rfc_input_t  pending_bytes [$];
	rfc_result_t expected_reports [$];

	logic in_fire        = 1'b0;
	int   push_gap       = 0;
	int   pop_gap        = 0;
	bit   quiet          = 1'b0;
	bit   stream_aligned = 1'b1;
	int   report_errors  = 0;
	int   cycle_count    = 0;

	rs485_frame_checker #(
		.FRAME_LEN(FrameLen),
		.ORDER_POS(OrderPos)
	) dut (
		.clk,
		.arst_n,
		.push,
		.full,
		.item,
		.empty,
		.pop,
		.result,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] stored_or_zero(int p);
		if (p < FrameLen) begin
			return frame_bytes[p];
		end
		return 8'd0;
	endfunction

	function automatic string describe(rfc_result_t r);
		return $sformatf("st=%0d src=%02h cls=%0d cmd=%02h par=%02h %02h %02h %02h",
			r.status, r.source_address, r.source_class, r.command,
			r.param_zero, r.param_one, r.param_two, r.param_three);
	endfunction

	task automatic predict_report(input rfc_input_t b);
		int unsigned p;
		int unsigned t;
		logic [7:0]  hi;
		logic [7:0]  lo;
		logic [7:0]  dst;
		logic [7:0]  src;
		rfc_result_t r;
		if (b.frame_begin) begin
			frame_pos = '0;
			weighted_sum = '0;
		end
		p = frame_pos;
		if (p >= FrameLen) begin
			p = 0;
		end
		frame_bytes[p] = b.rx_byte;
		if (p >= 2 && p <= FrameLen - 2) begin
			t = weighted_sum + b.rx_byte * p;
			if (cfg_modulus != 0) begin
				t = t % cfg_modulus;
			end
			weighted_sum = t[15:0];
		end
		if (p != FrameLen - 1) begin
			frame_pos = 6'(p + 1);
		end else begin
			hi = 8'(weighted_sum / 255);
			lo = 8'(weighted_sum % 255);
			if (hi == StartCode) begin
				hi = hi - 8'd1;
			end
			if (lo == StartCode) begin
				lo = lo - 8'd1;
			end
			dst = frame_bytes[FrameLen - 2];
			src = frame_bytes[FrameLen - 3];
			r = '0;
			if (b.rx_byte != StartCode) begin
				r.status = StatusBadStart;
			end else if (frame_bytes[1] != hi || frame_bytes[0] != lo) begin
				r.status = StatusBadSum;
			end else if (dst != cfg_own && dst != cfg_bcast) begin
				r.status = StatusNotHere;
			end else begin
				r.status = StatusOk;
			end
			r.source_address = src;
			if (src < LimitHandle) begin
				r.source_class = ClassHandle;
			end else if (src < LimitMaster) begin
				r.source_class = ClassMaster;
			end else if (src < LimitSensor) begin
				r.source_class = ClassSensor;
			end else begin
				r.source_class = ClassOther;
			end
			if (r.status == StatusOk) begin
				r.command     = stored_or_zero(OrderPos);
				r.param_zero  = stored_or_zero(OrderPos + 1);
				r.param_one   = stored_or_zero(OrderPos + 2);
				r.param_two   = stored_or_zero(OrderPos + 3);
				r.param_three = stored_or_zero(OrderPos + 4);
			end
			expected_reports.push_back(r);
			frame_pos = '0;
			weighted_sum = '0;
		end
	endtask

	always @(posedge clk) begin
		rfc_result_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= push && !full;
			if (push && !full) begin
				predict_report(item);
			end
			if (pop && !empty) begin
				if (expected_reports.size() == 0) begin
					report_errors++;
					if (report_errors <= ReportLimit) begin
						$display("%0t: report with none pending: %s", $time, describe(result));
					end
				end else begin
					want = expected_reports.pop_front();
					if (result.status !== want.status
						|| result.source_address !== want.source_address
						|| result.source_class !== want.source_class
						|| result.command !== want.command
						|| result.param_zero !== want.param_zero
						|| result.param_one !== want.param_one
						|| result.param_two !== want.param_two
						|| result.param_three !== want.param_three) begin
						report_errors++;
						if (report_errors <= ReportLimit) begin
							$display("%0t: report mismatch", $time);
							$display("  expected %s", describe(want));
							$display("  actual   %s", describe(result));
						end
					end
				end
			end
		end
	end

	// A request stays up until the checker takes it.
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || in_fire) begin
			if (push_gap != 0) begin
				push <= 1'b0;
				push_gap <= push_gap - 1;
			end else if (pending_bytes.size() == 0) begin
				push <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				push <= 1'b0;
				push_gap <= $urandom_range(0, 4);
			end else begin
				item <= pending_bytes.pop_front();
				push <= 1'b1;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_gap != 0) begin
			pop <= 1'b0;
			pop_gap <= pop_gap - 1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			pop <= 1'b0;
			pop_gap <= $urandom_range(0, 4);
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		case (idx)
			CfgModulus: begin
				cfg_modulus = val;
			end
			CfgLocal: begin
				cfg_own = val[7:0];
			end
			CfgBroadcast: begin
				cfg_bcast = val[7:0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_until_drained();
		while (pending_bytes.size() != 0 || push || expected_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Fills in checksum bytes and start code for the current modulus, then
	// spoils the frame as the kind asks.
	task automatic queue_frame(input logic [7:0] fb [FrameLen], input frame_kind_e kind,
		input bit restart);
		int          p;
		int unsigned t;
		logic [15:0] s;
		logic [7:0]  hi;
		logic [7:0]  lo;
		rfc_input_t  b;
		s = '0;
		for (p = 2; p <= FrameLen - 2; p++) begin
			t = s + fb[p] * p;
			if (cfg_modulus != 0) begin
				t = t % cfg_modulus;
			end
			s = t[15:0];
		end
		hi = 8'(s / 255);
		lo = 8'(s % 255);
		if (hi == StartCode) begin
			hi = hi - 8'd1;
		end
		if (lo == StartCode) begin
			lo = lo - 8'd1;
		end
		fb[0] = lo;
		fb[1] = hi;
		fb[FrameLen - 1] = StartCode;
		if (kind == FrameBadSum) begin
			if ($urandom_range(0, 1) == 1) begin
				fb[1] = fb[1] ^ (8'd1 << $urandom_range(0, 7));
			end else begin
				fb[0] = fb[0] ^ (8'd1 << $urandom_range(0, 7));
			end
		end else if (kind == FrameBadStart) begin
			fb[FrameLen - 1] = StartCode ^ (8'd1 << $urandom_range(0, 7));
		end
		for (p = 0; p < FrameLen; p++) begin
			b.rx_byte = fb[p];
			b.frame_begin = (p == 0) ? restart : 1'b0;
			pending_bytes.push_back(b);
		end
		stream_aligned = 1'b1;
	endtask

	task automatic queue_loose_bytes(input int count, input bit first_begin, input int begin_odds);
		int         k;
		rfc_input_t b;
		for (k = 0; k < count; k++) begin
			b.rx_byte = 8'($urandom_range(0, 255));
			if (k == 0) begin
				b.frame_begin = first_begin;
			end else begin
				b.frame_begin = (begin_odds != 0 && $urandom_range(1, begin_odds) == 1);
			end
			pending_bytes.push_back(b);
		end
		stream_aligned = 1'b0;
	endtask

	initial begin
		logic [7:0]  fr [FrameLen];
		int          ph;
		int          ev;
		int          roll;
		int          cls;
		frame_kind_e kind;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (ph = 0; ph < PhaseCount; ph++) begin
			if (ph > 0) begin
				wait_until_drained();
			end
			case (ph)
				1: begin
					write_register(CfgModulus, 16'd2);
					write_register(CfgLocal, 16'h00FF);
					write_register(CfgBroadcast, 16'h00FF);
				end
				2: begin
					write_register(CfgModulus, 16'd0);
					write_register(CfgLocal, 16'h0000);
					write_register(CfgBroadcast, 16'h00A5);
					write_register(CfgUnused, 16'hFFFF);
				end
				3: begin
					write_register(CfgModulus, 16'hFFFF);
					write_register(CfgLocal, 16'($urandom_range(0, 255)));
					write_register(CfgBroadcast, 16'($urandom_range(0, 255)));
				end
				4: begin
					write_register(CfgModulus, 16'($urandom_range(2, 300)));
					write_register(CfgLocal, 16'($urandom_range(0, 255)));
					write_register(CfgBroadcast, 16'($urandom_range(0, 255)));
				end
				5: begin
					write_register(CfgModulus, 16'($urandom_range(2, 20)));
					quiet = 1'b1;
				end
				default: begin
				end
			endcase

			if (ph == 0) begin
				// A low checksum byte that would equal the start code.
				foreach (fr[k]) fr[k] = 8'd0;
				fr[2] = 8'd85;
				fr[FrameLen - 2] = cfg_bcast;
				queue_frame(fr, FrameToBroadcast, 1'b1);

				foreach (fr[k]) fr[k] = 8'hFF;
				fr[FrameLen - 2] = cfg_own;
				queue_frame(fr, FrameToLocal, 1'b0);

				foreach (fr[k]) fr[k] = 8'($urandom_range(0, 255));
				fr[FrameLen - 3] = LimitHandle;
				fr[FrameLen - 2] = cfg_own;
				queue_frame(fr, FrameBadStart, 1'b0);

				fr[FrameLen - 3] = LimitSensor - 8'd1;
				queue_frame(fr, FrameBadSum, 1'b1);

				fr[FrameLen - 3] = LimitSensor;
				fr[FrameLen - 2] = 8'h11;
				queue_frame(fr, FrameNotHere, 1'b0);

				// A new frame begins in the middle of a broken one.
				queue_loose_bytes(3, 1'b1, 0);
				fr[FrameLen - 3] = LimitMaster - 8'd1;
				fr[FrameLen - 2] = cfg_own;
				queue_frame(fr, FrameToLocal, 1'b1);
			end

			// Finish the frame left open before the modulus changed.
			if (ph == 5) begin
				queue_loose_bytes(FrameLen / 2, 1'b0, 0);
			end

			for (ev = 0; ev < EventsPerPhase; ev++) begin
				roll = $urandom_range(0, 99);
				if (roll >= 85) begin
					queue_loose_bytes($urandom_range(1, FrameLen + 4), 1'b1, 5);
				end else begin
					foreach (fr[k]) fr[k] = 8'($urandom_range(0, 255));
					cls = $urandom_range(0, 3);
					if (cls == 3) begin
						fr[FrameLen - 3] = 8'($urandom_range(LimitSensor, 255));
					end else begin
						fr[FrameLen - 3] = (8'(cls) << 4) | 8'($urandom_range(0, 15));
					end
					if (roll < 35) begin
						kind = FrameToLocal;
					end else if (roll < 50) begin
						kind = FrameToBroadcast;
					end else if (roll < 60) begin
						kind = FrameBadStart;
					end else if (roll < 72) begin
						kind = FrameBadSum;
					end else begin
						kind = FrameNotHere;
					end
					fr[FrameLen - 2] = (kind == FrameToBroadcast) ? cfg_bcast : cfg_own;
					if (kind == FrameNotHere) begin
						do begin
							fr[FrameLen - 2] = 8'($urandom_range(0, 255));
						end while (fr[FrameLen - 2] == cfg_own || fr[FrameLen - 2] == cfg_bcast);
					end
					queue_frame(fr, kind, stream_aligned ? 1'($urandom_range(0, 1)) : 1'b1);
				end
			end

			if (ph == 4) begin
				queue_loose_bytes(FrameLen / 2, 1'b1, 0);
			end
		end

		wait_until_drained();
		if (report_errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
